>>> rtl/prosite_to_regex_translator_defines.svh
// Assertion macros used by the checker file.
`ifndef PROSITE_TO_REGEX_TRANSLATOR_DEFINES_SVH
`define PROSITE_TO_REGEX_TRANSLATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while reset is held.
`define PRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled while reset is held.
`define PRT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/prt_pkg.sv
// Shared types and character constants for the PROSITE-to-regex translator.
`default_nettype none
package prt_pkg;

  // Result-queue geometry
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // Most results one input character can cause
  localparam int unsigned MAXRES = 3;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_BAD_CHAR  = 2'd1,
    ERR_NO_PERIOD = 2'd2
  } prt_err_t;

  // One classified input character: the run of results it causes
  typedef struct packed {
    logic [MAXRES-1:0][7:0] chars;    // chars[0] goes out first
    logic [1:0]             cnt;      // results in the run, 1..3
    logic                   has_char; // 0: single status-only result
    logic                   done;     // run ends the pattern
    prt_err_t               err;      // meaningful when done
  } prt_job_t;

  localparam logic [7:0] CH_DASH    = 8'h2D; // -
  localparam logic [7:0] CH_DOT     = 8'h2E; // .
  localparam logic [7:0] CH_COMMA   = 8'h2C; // ,
  localparam logic [7:0] CH_LT      = 8'h3C; // <
  localparam logic [7:0] CH_GT      = 8'h3E; // >
  localparam logic [7:0] CH_LPAREN  = 8'h28; // (
  localparam logic [7:0] CH_RPAREN  = 8'h29; // )
  localparam logic [7:0] CH_LBRACK  = 8'h5B; // [
  localparam logic [7:0] CH_RBRACK  = 8'h5D; // ]
  localparam logic [7:0] CH_LBRACE  = 8'h7B; // {
  localparam logic [7:0] CH_RBRACE  = 8'h7D; // }
  localparam logic [7:0] CH_CARET   = 8'h5E; // ^
  localparam logic [7:0] CH_DOLLAR  = 8'h24; // $
  localparam logic [7:0] CH_X_UP    = 8'h58; // X
  localparam logic [7:0] CH_X_LOW   = 8'h78; // x
  localparam logic [7:0] CH_A_UP    = 8'h41;
  localparam logic [7:0] CH_Z_UP    = 8'h5A;
  localparam logic [7:0] CH_A_LOW   = 8'h61;
  localparam logic [7:0] CH_Z_LOW   = 8'h7A;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CASE_DELTA = 8'h20;

endpackage
`default_nettype wire

>>> rtl/prosite_to_regex_translator.sv
// Top level of the streaming PROSITE-to-regex translator.
//
// Input channel: one pattern character per transfer (in_char), with
// in_pattern_end on the last character of a pattern. Output channel: one
// regex character per transfer, plus run_last (last result of that input
// character), pattern_done and error_code on the pattern's final result.
// A final character that maps to nothing yields one status-only result
// (out_char_valid = 0, out_char = 0); silent middle characters yield none.
// An accepted run is written into the queue at the input edge and is
// loaded into the output register once that register is free.
// The output side moves one result per cycle while the receiver does not
// stall, so an input character holds it for each result of its run; the
// back end's single output register is the limit. Input transfers proceed
// every cycle while the two-entry run queue has room.
// Reset clears the group and error flags, the queue and the output valid.
// When the receiver stalls, the output holds; the queue then fills and
// in_stall rises, so no character is lost or repeated.
`default_nettype none
module prosite_to_regex_translator (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       in_pattern_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic            out_char_valid,
  output logic            out_run_last,
  output logic            out_pattern_done,
  output logic [1:0]      out_error_code
);

  // Front -> queue
  logic              q_push;
  prt_pkg::prt_job_t q_push_job;
  logic              q_full;
  // Queue -> back
  logic              q_pop;
  logic              q_head_valid;
  prt_pkg::prt_job_t q_head_job;

  // Classifier: group tracking, validation, char mapping
  prt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char        (in_char),
    .in_pattern_end (in_pattern_end),
    .q_full         (q_full),
    .push           (q_push),
    .push_job       (q_push_job)
  );

  // Decouples input transfers from output stalls
  prt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  // Serializer: one result per output transfer
  prt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_head_valid),
    .head_job         (q_head_job),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_char_valid   (out_char_valid),
    .out_run_last     (out_run_last),
    .out_pattern_done (out_pattern_done),
    .out_error_code   (out_error_code)
  );

endmodule
`default_nettype wire

>>> rtl/prt_front.sv
// Front end: accepts pattern characters, tracks group/error state, builds result runs.
`default_nettype none
module prt_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      in_char,
  input  wire logic            in_pattern_end,
  input  wire logic            q_full,
  output logic                 push,
  output prt_pkg::prt_job_t    push_job
);

  logic in_group_r, in_group_nxt;
  logic bad_char_seen_r, bad_char_seen_nxt;
  logic accept;

  logic                              is_lower, is_letter, is_digit, is_punct, allowed;
  logic                              is_sep, opens;
  logic [7:0]                        up;
  logic [1:0]                        n;
  logic [prt_pkg::MAXRES-1:0][7:0]   chars;
  logic                              grp_after, bad_after;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign is_lower  = (in_char >= prt_pkg::CH_A_LOW) && (in_char <= prt_pkg::CH_Z_LOW);
  assign up        = is_lower ? (in_char - prt_pkg::CASE_DELTA) : in_char;
  assign is_letter = (up >= prt_pkg::CH_A_UP) && (up <= prt_pkg::CH_Z_UP);
  assign is_digit  = (in_char >= prt_pkg::CH_0) && (in_char <= prt_pkg::CH_9);
  assign is_sep    = (in_char == prt_pkg::CH_DASH) || (in_char == prt_pkg::CH_DOT) ||
                     (in_char == prt_pkg::CH_GT);
  assign is_punct  = is_sep || (in_char == prt_pkg::CH_LBRACK) ||
                     (in_char == prt_pkg::CH_RBRACK) || (in_char == prt_pkg::CH_COMMA) ||
                     (in_char == prt_pkg::CH_LPAREN) || (in_char == prt_pkg::CH_RPAREN) ||
                     (in_char == prt_pkg::CH_LBRACE) || (in_char == prt_pkg::CH_RBRACE) ||
                     (in_char == prt_pkg::CH_LT);
  assign allowed   = is_letter || is_digit || is_punct;

  // Group opens before a non-X letter, '[' or '{'
  assign opens = !in_group_r &&
                 ((is_letter && (up != prt_pkg::CH_X_UP)) ||
                  (in_char == prt_pkg::CH_LBRACK) || (in_char == prt_pkg::CH_LBRACE));

  always_comb begin
    n         = 2'd0;
    chars     = '0;
    grp_after = in_group_r;
    if (is_sep) begin
      if (in_group_r) begin
        chars[n]  = prt_pkg::CH_RPAREN;
        n         = n + 2'd1;
        grp_after = 1'b0;
      end
      if (in_char == prt_pkg::CH_GT) begin
        chars[n] = prt_pkg::CH_DOLLAR;
        n        = n + 2'd1;
      end
    end else if (in_char == prt_pkg::CH_LT) begin
      chars[n] = prt_pkg::CH_CARET;
      n        = n + 2'd1;
    end else begin
      if (opens) begin
        chars[n]  = prt_pkg::CH_LPAREN;
        n         = n + 2'd1;
        grp_after = 1'b1;
      end
      unique case (in_char)
        prt_pkg::CH_LPAREN: begin
          chars[n] = prt_pkg::CH_LBRACE;
          n        = n + 2'd1;
        end
        prt_pkg::CH_RPAREN: begin
          chars[n] = prt_pkg::CH_RBRACE;
          n        = n + 2'd1;
        end
        prt_pkg::CH_LBRACE: begin
          chars[n] = prt_pkg::CH_LBRACK;
          n        = n + 2'd1;
          chars[n] = prt_pkg::CH_CARET;
          n        = n + 2'd1;
        end
        prt_pkg::CH_RBRACE: begin
          chars[n] = prt_pkg::CH_RBRACK;
          n        = n + 2'd1;
        end
        prt_pkg::CH_X_UP, prt_pkg::CH_X_LOW: begin
          chars[n] = prt_pkg::CH_DOT;
          n        = n + 2'd1;
        end
        default: begin
          chars[n] = up;
          n        = n + 2'd1;
        end
      endcase
    end
  end

  assign bad_after = bad_char_seen_r || !allowed;

  always_comb begin
    push_job.chars    = chars;
    push_job.has_char = (n != 2'd0);
    push_job.cnt      = (n != 2'd0) ? n : 2'd1;
    push_job.done     = in_pattern_end;
    if (bad_after) begin
      push_job.err = prt_pkg::ERR_BAD_CHAR;
    end else if (in_char != prt_pkg::CH_DOT) begin
      push_job.err = prt_pkg::ERR_NO_PERIOD;
    end else begin
      push_job.err = prt_pkg::ERR_OK;
    end
  end

  // Silent middle characters queue nothing
  assign push = accept && ((n != 2'd0) || in_pattern_end);

  always_comb begin
    in_group_nxt      = in_group_r;
    bad_char_seen_nxt = bad_char_seen_r;
    if (accept) begin
      in_group_nxt      = in_pattern_end ? 1'b0 : grp_after;
      bad_char_seen_nxt = in_pattern_end ? 1'b0 : bad_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_group_r      <= 1'b0;
      bad_char_seen_r <= 1'b0;
    end else begin
      in_group_r      <= in_group_nxt;
      bad_char_seen_r <= bad_char_seen_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/prt_queue.sv
// Short queue of result runs between front and back end.
`default_nettype none
module prt_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire prt_pkg::prt_job_t  push_job,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output prt_pkg::prt_job_t       head_job
);

  prt_pkg::prt_job_t               mem_r [prt_pkg::QDEPTH];
  logic [prt_pkg::QAW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [prt_pkg::QAW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [prt_pkg::QCW-1:0]         count_r, count_nxt;
  logic                            do_push, do_pop;

  assign full       = (count_r == prt_pkg::QCW'(prt_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [prt_pkg::QAW-1:0] ptr_inc(input logic [prt_pkg::QAW-1:0] p);
    ptr_inc = (p == prt_pkg::QAW'(prt_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

>>> rtl/prt_back.sv
// Back end: walks each queued run and drives one result per transfer.
`default_nettype none
module prt_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               head_valid,
  input  wire prt_pkg::prt_job_t  head_job,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_char,
  output logic                    out_char_valid,
  output logic                    out_run_last,
  output logic                    out_pattern_done,
  output logic [1:0]              out_error_code
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r;
  logic       out_char_valid_r, out_run_last_r, out_pattern_done_r;
  logic [1:0] out_error_code_r;
  logic       load, run_end;

  assign load    = head_valid && (!out_valid_r || !out_stall);
  assign run_end = (idx_r == (head_job.cnt - 2'd1));
  assign pop     = load && run_end;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = run_end ? 2'd0 : idx_r + 2'd1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r         <= head_job.chars[idx_r];
      out_char_valid_r   <= head_job.has_char;
      out_run_last_r     <= run_end;
      out_pattern_done_r <= run_end && head_job.done;
      out_error_code_r   <= (run_end && head_job.done) ? head_job.err : prt_pkg::ERR_OK;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char         = out_char_r;
  assign out_char_valid   = out_char_valid_r;
  assign out_run_last     = out_run_last_r;
  assign out_pattern_done = out_pattern_done_r;
  assign out_error_code   = out_error_code_r;

endmodule
`default_nettype wire

>>> rtl/prt_checker.sv
// Port-level checks for the translator, bound to the top level.
`default_nettype none
`include "prosite_to_regex_translator_defines.svh"
module prt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_char,
  input wire logic       out_char_valid,
  input wire logic       out_run_last,
  input wire logic       out_pattern_done,
  input wire logic [1:0] out_error_code
);

  `PRT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_char) && $stable(out_run_last) && $stable(out_pattern_done), "stalled result changed")
  `PRT_ASSERT_NOW(a_err_only_at_end, out_valid && !out_pattern_done, out_error_code == prt_pkg::ERR_OK, "error code outside pattern end")
  `PRT_ASSERT_NOW(a_done_ends_run, out_valid && out_pattern_done, out_run_last, "pattern end not on last result of run")
  `PRT_ASSERT_NOW(a_status_only, out_valid && !out_char_valid, out_pattern_done && out_run_last && (out_char == 8'd0), "bad status-only result")
  `PRT_ASSERT_NOW(a_err_range, out_valid, out_error_code != 2'd3, "undefined error code")

endmodule

bind prosite_to_regex_translator prt_checker u_prt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_char         (out_char),
  .out_char_valid   (out_char_valid),
  .out_run_last     (out_run_last),
  .out_pattern_done (out_pattern_done),
  .out_error_code   (out_error_code)
);
`default_nettype wire
